// ----- hdl/sorted_table_engine_core_macros.svh -----
// assertion macros for the sorted table engine
`ifndef SORTED_TABLE_ENGINE_CORE_MACROS_SVH
`define SORTED_TABLE_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define STE_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sorted table engine assertion failed");

// next-cycle implication
`define STE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sorted table engine assertion failed");

`endif

// ----- hdl/sortab_pkg.sv -----
// shared constants and types of the sorted table engine
`timescale 1ns / 1ps

package sortab_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 64;
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 6;
    localparam int STAT_W   = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_PREPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam logic [1:0] MODE_HOLD = 2'd0;
    localparam logic [1:0] MODE_INS  = 2'd1;
    localparam logic [1:0] MODE_DEL  = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] target;
        logic [VAL_W-1:0] new_value;
        logic [IDX_W-1:0] read_pos;
        logic [CNT_W-1:0] count;
    } cmd_t;

endpackage

// ----- hdl/sortab_cell.sv -----
// one table cell: holds an entry, shifts with its neighbors, compares locally
`timescale 1ns / 1ps

module sortab_cell (
    input  logic                          aclk,
    input  sortab_pkg::cmd_t              cmd,
    input  logic [sortab_pkg::IDX_W-1:0]  idx,
    input  logic [sortab_pkg::VAL_W-1:0]  left_value,
    input  logic [sortab_pkg::VAL_W-1:0]  right_value,
    output logic [sortab_pkg::VAL_W-1:0]  value,
    output logic                          lt,
    output logic                          ok,
    output logic [sortab_pkg::VAL_W-1:0]  read_term
);

    logic [sortab_pkg::VAL_W-1:0] value_reg;
    logic [sortab_pkg::VAL_W-1:0] value_next;
    logic                         valid;

    always_comb begin
        value_next = value_reg;
        unique case (cmd.mode)
            sortab_pkg::MODE_INS: begin
                if (idx > cmd.target) begin
                    value_next = left_value;
                end else if (idx == cmd.target) begin
                    value_next = cmd.new_value;
                end
            end
            sortab_pkg::MODE_DEL: begin
                if (idx >= cmd.target) begin
                    value_next = right_value;
                end
            end
            sortab_pkg::MODE_HOLD: begin
                value_next = value_reg;
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign valid     = ({1'b0, idx} < cmd.count);
    assign lt        = valid && ($signed(value_reg) < $signed(cmd.new_value));
    assign ok        = !(valid && (idx != '0)) || ($signed(left_value) < $signed(value_reg));
    assign read_term = (idx == cmd.read_pos) ? value_reg : '0;
    assign value     = value_reg;

endmodule

// ----- hdl/sorted_table_engine_core.sv -----
// sorted table engine top level: cell chain, request decode, result stages
// an accepted request's result goes to the holding stage and then to the output register,
// where the order flag is sampled from the updated chain; one request per cycle unless
// back-pressure stalls the holding stage; the chain applies each operation as it is accepted
// reset: synchronous active-low aresetn empties the table and invalidates both result stages
// entries need no clearing pass, positions at or beyond the count are never read
`timescale 1ns / 1ps
`include "sorted_table_engine_core_macros.svh"

module sorted_table_engine_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sortab_pkg::FUNC_W-1:0]   s_func,
    input  logic signed [sortab_pkg::VAL_W-1:0] s_new_value,
    input  logic [sortab_pkg::POS_W-1:0]    s_position,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [sortab_pkg::VAL_W-1:0] m_read_value,
    output logic [sortab_pkg::STAT_W-1:0]   m_status,
    output logic [sortab_pkg::CNT_W-1:0]    m_entry_count,
    output logic                            m_is_sorted
);

    logic [sortab_pkg::VAL_W-1:0] cell_value [sortab_pkg::CAPACITY];
    logic [sortab_pkg::VAL_W-1:0] cell_read  [sortab_pkg::CAPACITY];
    logic [sortab_pkg::CAPACITY-1:0] cell_lt;
    logic [sortab_pkg::CAPACITY-1:0] cell_ok;

    logic [sortab_pkg::CNT_W-1:0]  count_reg;
    logic [sortab_pkg::CNT_W-1:0]  count_next;
    sortab_pkg::cmd_t              cmd;
    logic                          accept;
    logic                          move;
    logic                          is_add;
    logic                          full;
    logic                          oob;
    logic [sortab_pkg::IDX_W-1:0]  ins_pos;
    logic [sortab_pkg::VAL_W-1:0]  read_data;
    logic [sortab_pkg::VAL_W-1:0]  rd_next;
    logic [sortab_pkg::STAT_W-1:0] status_next;
    logic                          pend_full;
    logic                          read_acc;

    logic                          pend_reg;
    logic [sortab_pkg::VAL_W-1:0]  pend_rd_reg;
    logic [sortab_pkg::STAT_W-1:0] pend_status_reg;
    logic [sortab_pkg::CNT_W-1:0]  pend_count_reg;
    logic                          m_valid_reg;
    logic [sortab_pkg::VAL_W-1:0]  m_rd_reg;
    logic [sortab_pkg::STAT_W-1:0] m_status_reg;
    logic [sortab_pkg::CNT_W-1:0]  m_count_reg;
    logic                          m_sorted_reg;

    // cell chain
    for (genvar i = 0; i < sortab_pkg::CAPACITY; i++) begin : g_cell
        logic [sortab_pkg::VAL_W-1:0] left_v;
        logic [sortab_pkg::VAL_W-1:0] right_v;
        if (i == 0) begin : g_first
            assign left_v = '0;
        end else begin : g_mid_l
            assign left_v = cell_value[i-1];
        end
        if (i == sortab_pkg::CAPACITY - 1) begin : g_last
            assign right_v = '0;
        end else begin : g_mid_r
            assign right_v = cell_value[i+1];
        end
        sortab_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .idx         (sortab_pkg::IDX_W'(i)),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[i]),
            .lt          (cell_lt[i]),
            .ok          (cell_ok[i]),
            .read_term   (cell_read[i])
        );
    end

    assign move    = pend_reg && (!m_valid_reg || m_ready);
    assign s_ready = !pend_reg || move;
    assign accept  = s_valid && s_ready;

    assign is_add = (s_func == sortab_pkg::FUNC_INSERT) || (s_func == sortab_pkg::FUNC_PREPEND)
                 || (s_func == sortab_pkg::FUNC_APPEND);
    assign full   = (count_reg == sortab_pkg::CNT_W'(sortab_pkg::CAPACITY));
    assign oob    = ({1'b0, s_position} >= count_reg);

    // first cell not below the new value
    always_comb begin
        ins_pos = '0;
        for (int i = sortab_pkg::CAPACITY - 1; i >= 0; i--) begin
            if (!cell_lt[i]) begin
                ins_pos = sortab_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        read_data = '0;
        for (int i = 0; i < sortab_pkg::CAPACITY; i++) begin
            read_data = read_data | cell_read[i];
        end
    end

    always_comb begin
        cmd.mode      = sortab_pkg::MODE_HOLD;
        cmd.target    = '0;
        cmd.new_value = s_new_value;
        cmd.read_pos  = sortab_pkg::IDX_W'(s_position);
        cmd.count     = count_reg;
        count_next    = count_reg;
        rd_next       = '0;
        status_next   = sortab_pkg::STAT_OK;
        if (is_add) begin
            if (full) begin
                status_next = sortab_pkg::STAT_FULL;
            end else begin
                cmd.mode   = accept ? sortab_pkg::MODE_INS : sortab_pkg::MODE_HOLD;
                count_next = count_reg + 1'b1;
                unique case (s_func)
                    sortab_pkg::FUNC_INSERT:  cmd.target = ins_pos;
                    sortab_pkg::FUNC_PREPEND: cmd.target = '0;
                    default:                  cmd.target = count_reg[sortab_pkg::IDX_W-1:0];
                endcase
            end
        end else if ((s_func == sortab_pkg::FUNC_REMOVE)
                     || (s_func == sortab_pkg::FUNC_READ)) begin
            if (oob) begin
                status_next = sortab_pkg::STAT_RANGE;
            end else if (s_func == sortab_pkg::FUNC_REMOVE) begin
                cmd.mode   = accept ? sortab_pkg::MODE_DEL : sortab_pkg::MODE_HOLD;
                cmd.target = sortab_pkg::IDX_W'(s_position);
                count_next = count_reg - 1'b1;
            end else begin
                rd_next = read_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                pend_reg <= 1'b1;
            end else if (move) begin
                pend_reg <= 1'b0;
            end
            if (move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_rd_reg     <= rd_next;
            pend_status_reg <= status_next;
            pend_count_reg  <= count_next;
        end
        if (move) begin
            m_rd_reg     <= pend_rd_reg;
            m_status_reg <= pend_status_reg;
            m_count_reg  <= pend_count_reg;
            m_sorted_reg <= &cell_ok;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_rd_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;
    assign m_is_sorted   = m_sorted_reg;

    assign pend_full = pend_reg && (pend_status_reg == sortab_pkg::STAT_FULL);
    assign read_acc  = accept && (s_func == sortab_pkg::FUNC_READ);

    `STE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= sortab_pkg::CNT_W'(sortab_pkg::CAPACITY))
    `STE_ASSERT_NEXT(a_read_keeps_count, read_acc, count_reg == $past(count_reg))
    `STE_ASSERT_NOW(a_full_count, pend_full, pend_count_reg == sortab_pkg::CNT_W'(64))
    `STE_ASSERT_NEXT(a_pend_moves, move, m_valid_reg)

endmodule
